@@ rtl/core/ebp_pkg.sv @@
// Shared constants and types for the Euler basis projection block.
`default_nettype none
package ebp_pkg;

    // Taylor coefficients of sin(pi/2 * t) in unsigned Q30.
    localparam logic [30:0] TAY1 = 31'd1686629713;
    localparam logic [30:0] TAY3 = 31'd693598668;
    localparam logic [30:0] TAY5 = 31'd85569306;
    localparam logic [30:0] TAY7 = 31'd5026995;
    localparam logic [30:0] TAY9 = 31'd172272;

    // One in Q30 and a quarter turn of the 32-bit phase.
    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Largest magnitude of a Q1.16 basis component.
    localparam int UNIT_Q16 = 65536;

    // Sine and cosine of one angle, signed Q1.16.
    typedef struct packed {
        logic signed [17:0] sin;
        logic signed [17:0] cos;
    } trig_t;

endpackage
`default_nettype wire

@@ rtl/core/euler_basis_projection.sv @@
// Top level: Euler angle rotation basis and projection of a point onto it.
// Depth: 13 register stages, each with its own valid bit.
// Throughput: one transaction per cycle while not stalled; seven stages of trig, three of basis,
// three of dot product, each stage holding at most one multiply.
// The whole pipeline stalls together when a result waits on out_ready.
// Reset clears only the stage valid bits; data registers are not reset.
`default_nettype none
module euler_basis_projection #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    input  wire logic [15:0]        angle_x,
    input  wire logic [15:0]        angle_y,
    input  wire logic [15:0]        angle_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [17:0]      forward_x,
    output logic signed [17:0]      forward_y,
    output logic signed [17:0]      forward_z,
    output logic signed [17:0]      right_x,
    output logic signed [17:0]      right_y,
    output logic signed [17:0]      right_z,
    output logic signed [17:0]      up_x,
    output logic signed [17:0]      up_y,
    output logic signed [17:0]      up_z,
    output logic signed [31:0]      coef_forward,
    output logic signed [31:0]      coef_right,
    output logic signed [31:0]      coef_up
);

    localparam int DEPTH   = 13;
    localparam int PT_LAST = 9;

    logic en;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    ebp_pkg::trig_t tx, ty, tz;

    logic signed [31:0] pt_reg [PT_LAST+1][3];

    // Stage 8: pairwise trig products.
    logic signed [34:0] cycz_reg, cysz_reg, sxsy_reg, cxsz_reg, cxcz_reg;
    logic signed [34:0] sxsz_reg, cysx_reg, czsx_reg, cxsy_reg, cxcy_reg;
    logic signed [17:0] sy8_reg, sz8_reg, cz8_reg;

    // Stage 9: Q48 sums; stage 10 onward: rounded basis.
    logic signed [53:0] v_reg [9];
    logic signed [53:0] v_next[9];
    logic signed [17:0] b_reg [4][9];
    logic signed [17:0] b_next[9];

    // Dot product stages.
    logic signed [49:0] dp_reg [9];
    logic signed [51:0] acc_reg[3];
    logic signed [31:0] coef_reg[3];
    logic signed [31:0] coef_next[3];

    // One enable for every stage: advance unless a result is blocked.
    assign en       = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready = en;

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next = {valid_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Trig pipelines for the three angles.
    ebp_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_x (
        .clk(clk), .en(en), .angle(angle_x), .trig(tx)
    );
    ebp_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_y (
        .clk(clk), .en(en), .angle(angle_y), .trig(ty)
    );
    ebp_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_z (
        .clk(clk), .en(en), .angle(angle_z), .trig(tz)
    );

    // Q48 basis sums from the pairwise products.
    always_comb
    begin
        v_next[0] = 54'(cycz_reg) <<< 16;
        v_next[1] = -(54'(cysz_reg) <<< 16);
        v_next[2] = 54'(sy8_reg) <<< 32;
        v_next[3] = 54'(sxsy_reg) * 54'(cz8_reg) + (54'(cxsz_reg) <<< 16);
        v_next[4] = (54'(cxcz_reg) <<< 16) - 54'(sxsz_reg) * 54'(sy8_reg);
        v_next[5] = -(54'(cysx_reg) <<< 16);
        v_next[6] = (54'(sxsz_reg) <<< 16) - 54'(cxcz_reg) * 54'(sy8_reg);
        v_next[7] = (54'(czsx_reg) <<< 16) + 54'(cxsy_reg) * 54'(sz8_reg);
        v_next[8] = 54'(cxcy_reg) <<< 16;
    end

    // Round half up to Q1.16 and clamp to the unit range.
    always_comb
    begin
        logic signed [53:0] r;
        for (int i = 0; i < 9; i++)
        begin
            r = (v_reg[i] + 54'sd2147483648) >>> 32;
            if (r > 54'sd65536)
                b_next[i] = 18'sd65536;
            else if (r < -54'sd65536)
                b_next[i] = -18'sd65536;
            else
                b_next[i] = 18'(r);
        end
    end

    // Round half up to Q16.16 and saturate to 32 bits.
    always_comb
    begin
        logic signed [51:0] r;
        for (int i = 0; i < 3; i++)
        begin
            r = (acc_reg[i] + 52'sd32768) >>> 16;
            if (r > 52'sd2147483647)
                coef_next[i] = 32'sh7FFF_FFFF;
            else if (r < -52'sd2147483648)
                coef_next[i] = 32'sh8000_0000;
            else
                coef_next[i] = 32'(r);
        end
    end

    // Data pipeline registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg[0][0] <= point_x;
            pt_reg[0][1] <= point_y;
            pt_reg[0][2] <= point_z;
            for (int k = 1; k <= PT_LAST; k++)
            begin
                pt_reg[k] <= pt_reg[k-1];
            end

            cycz_reg <= 35'(ty.cos) * 35'(tz.cos);
            cysz_reg <= 35'(ty.cos) * 35'(tz.sin);
            sxsy_reg <= 35'(tx.sin) * 35'(ty.sin);
            cxsz_reg <= 35'(tx.cos) * 35'(tz.sin);
            cxcz_reg <= 35'(tx.cos) * 35'(tz.cos);
            sxsz_reg <= 35'(tx.sin) * 35'(tz.sin);
            cysx_reg <= 35'(ty.cos) * 35'(tx.sin);
            czsx_reg <= 35'(tz.cos) * 35'(tx.sin);
            cxsy_reg <= 35'(tx.cos) * 35'(ty.sin);
            cxcy_reg <= 35'(tx.cos) * 35'(ty.cos);
            sy8_reg  <= ty.sin;
            sz8_reg  <= tz.sin;
            cz8_reg  <= tz.cos;

            v_reg    <= v_next;
            b_reg[0] <= b_next;
            b_reg[1] <= b_reg[0];
            b_reg[2] <= b_reg[1];
            b_reg[3] <= b_reg[2];

            for (int j = 0; j < 3; j++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dp_reg[3*j+c] <= 50'(pt_reg[PT_LAST][c]) * 50'(b_reg[0][3*j+c]);
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                acc_reg[j] <= 52'(dp_reg[3*j]) + 52'(dp_reg[3*j+1]) + 52'(dp_reg[3*j+2]);
            end
            coef_reg <= coef_next;
        end
    end

    // Result ports.
    assign out_valid    = valid_reg[DEPTH-1];
    assign forward_x    = b_reg[3][0];
    assign forward_y    = b_reg[3][1];
    assign forward_z    = b_reg[3][2];
    assign right_x      = b_reg[3][3];
    assign right_y      = b_reg[3][4];
    assign right_z      = b_reg[3][5];
    assign up_x         = b_reg[3][6];
    assign up_y         = b_reg[3][7];
    assign up_z         = b_reg[3][8];
    assign coef_forward = coef_reg[0];
    assign coef_right   = coef_reg[1];
    assign coef_up      = coef_reg[2];

    // A blocked result holds its forward and up coefficients.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coef_forward) && $stable(coef_up))
        else $error("blocked result changed");

    // Input is refused exactly while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready disagrees with output stall");

    // The forward and up z components stay within the unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> forward_z <= 18'sd65536 && forward_z >= -18'sd65536
                   && up_z <= 18'sd65536 && up_z >= -18'sd65536)
        else $error("basis component out of range");

    // An accepted transaction enters the first pipeline stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transaction lost");

endmodule
`default_nettype wire

@@ rtl/core/ebp_sincos.sv @@
// Seven-stage pipelined sine and cosine of one binary angle.
`default_nettype none
module ebp_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [15:0]   angle,
    output ebp_pkg::trig_t     trig
);

    localparam int SHIFT = 32 - ANGLE_BITS;

    // Lane 0 computes the sine, lane 1 the cosine.
    logic [31:0] phase [2];
    logic [30:0] t_a_reg  [2];
    logic        neg_a_reg[2];
    logic [30:0] t_b_reg  [2];
    logic [30:0] t2_b_reg [2];
    logic        neg_b_reg[2];
    logic [30:0] t_c_reg  [2];
    logic [30:0] t2_c_reg [2];
    logic [30:0] p_c_reg  [2];
    logic        neg_c_reg[2];
    logic [30:0] t_d_reg  [2];
    logic [30:0] t2_d_reg [2];
    logic [30:0] p_d_reg  [2];
    logic        neg_d_reg[2];
    logic [30:0] t_e_reg  [2];
    logic [30:0] t2_e_reg [2];
    logic [30:0] p_e_reg  [2];
    logic        neg_e_reg[2];
    logic [30:0] t_f_reg  [2];
    logic [30:0] p_f_reg  [2];
    logic        neg_f_reg[2];
    logic signed [17:0] res_reg[2];

    logic [61:0] sq      [2];
    logic [61:0] prod_c  [2];
    logic [61:0] prod_d  [2];
    logic [61:0] prod_e  [2];
    logic [61:0] prod_f  [2];
    logic [61:0] prod_g  [2];
    logic [16:0] rnd     [2];
    logic [16:0] mag     [2];

    // Phase of the angle and of the angle a quarter turn ahead.
    always_comb
    begin
        phase[0] = 32'({16'd0, angle} << SHIFT);
        phase[1] = phase[0] + ebp_pkg::QUARTER_TURN;
    end

    // Products of each Horner step and the final rounding.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sq[i]     = 62'(t_a_reg[i]) * 62'(t_a_reg[i]);
            prod_c[i] = 62'(ebp_pkg::TAY9) * 62'(t2_b_reg[i]);
            prod_d[i] = 62'(p_c_reg[i]) * 62'(t2_c_reg[i]);
            prod_e[i] = 62'(p_d_reg[i]) * 62'(t2_d_reg[i]);
            prod_f[i] = 62'(p_e_reg[i]) * 62'(t2_e_reg[i]);
            prod_g[i] = 62'(p_f_reg[i]) * 62'(t_f_reg[i]);
            rnd[i]    = 17'((prod_g[i][60:30] + 31'd8192) >> 14);
            mag[i]    = (rnd[i] > 17'(ebp_pkg::UNIT_Q16)) ? 17'(ebp_pkg::UNIT_Q16) : rnd[i];
        end
    end

    // Pipeline registers; the whole chain holds while en is low.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                t_a_reg[i]   <= phase[i][30] ? (ebp_pkg::ONE_Q30 - {1'b0, phase[i][29:0]})
                                             : {1'b0, phase[i][29:0]};
                neg_a_reg[i] <= phase[i][31];

                t_b_reg[i]   <= t_a_reg[i];
                t2_b_reg[i]  <= sq[i][60:30];
                neg_b_reg[i] <= neg_a_reg[i];

                t_c_reg[i]   <= t_b_reg[i];
                t2_c_reg[i]  <= t2_b_reg[i];
                p_c_reg[i]   <= 31'(ebp_pkg::TAY7 - prod_c[i][61:30]);
                neg_c_reg[i] <= neg_b_reg[i];

                t_d_reg[i]   <= t_c_reg[i];
                t2_d_reg[i]  <= t2_c_reg[i];
                p_d_reg[i]   <= 31'(ebp_pkg::TAY5 - prod_d[i][61:30]);
                neg_d_reg[i] <= neg_c_reg[i];

                t_e_reg[i]   <= t_d_reg[i];
                t2_e_reg[i]  <= t2_d_reg[i];
                p_e_reg[i]   <= 31'(ebp_pkg::TAY3 - prod_e[i][61:30]);
                neg_e_reg[i] <= neg_d_reg[i];

                t_f_reg[i]   <= t_e_reg[i];
                p_f_reg[i]   <= 31'(ebp_pkg::TAY1 - prod_f[i][61:30]);
                neg_f_reg[i] <= neg_e_reg[i];

                res_reg[i]   <= neg_f_reg[i] ? -$signed({1'b0, mag[i]})
                                             : $signed({1'b0, mag[i]});
            end
        end
    end

    assign trig.sin = res_reg[0];
    assign trig.cos = res_reg[1];

endmodule
`default_nettype wire
